// ===== rtl/e2c_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package e2c_pkg;

  localparam int EpochWidth   = 32;
  localparam int DaysWidth    = 16;   // up to 49710 whole days
  localparam int TodWidth     = 17;   // seconds within a day, below 86400
  localparam int YoffWidth    = 8;    // years past the first year, 0..136
  localparam int DoyWidth     = 9;    // day within the year, 0..365
  localparam int Months       = 12;
  localparam int MonthIdxWidth = 4;

  localparam int SecsPerDay   = 24 * 60 * 60;
  localparam int SecsPerHour  = 3600;
  localparam int SecsPerMin   = 60;
  localparam int FirstYear    = 1970;
  localparam int LastYoff     = 136;          // 2106
  localparam int CenturyYoff  = 2100 - FirstYear;  // 2100 is not a leap year

  // reciprocal of 675 (86400 = 675 << 7), exact for 25-bit operands
  localparam int DayRecipShift = 35;
  localparam logic [25:0] DayRecip = 26'd50903317;
  // reciprocal of 225 (3600 = 225 << 4), exact below 5400
  localparam int HourRecipShift = 20;
  localparam logic [12:0] HourRecip = 13'd4661;
  // reciprocal of 15 (60 = 15 << 2), exact below 900
  localparam int MinRecipShift = 14;
  localparam logic [10:0] MinRecip = 11'd1093;

  typedef logic [EpochWidth-1:0]    epoch_t;
  typedef logic [DaysWidth-1:0]     days_t;
  typedef logic [TodWidth-1:0]      tod_t;
  typedef logic [YoffWidth-1:0]     yoff_t;
  typedef logic [DoyWidth-1:0]      doy_t;
  typedef logic [MonthIdxWidth-1:0] midx_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } clock_t;

  // first day of each month in a common year, sums of 31 28 31 30 31 30 31 31 30 31 30 31
  localparam doy_t MonthStart [Months] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // days from the epoch to the first day of year FirstYear + n
  function automatic logic [16:0] year_start(input yoff_t n);
    logic [16:0] base;
    logic [16:0] leaps;
    base  = 17'(n) * 17'd365;
    leaps = 17'((9'(n) + 9'd1) >> 2);
    if (n > yoff_t'(CenturyYoff)) begin
      leaps = leaps - 17'd1;
    end
    return base + leaps;
  endfunction

  // divisible by 4; the only century in range (2100) is excluded, 2000 divides by 400
  function automatic logic is_leap(input yoff_t n);
    return (n[1:0] == 2'd2) && (n != yoff_t'(CenturyYoff));
  endfunction

  function automatic doy_t month_start(input midx_t m, input logic leap);
    doy_t s;
    s = MonthStart[m];
    if (leap && (m >= midx_t'(2))) begin
      s = s + doy_t'(1);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/epoch_seconds_to_calendar_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into Gregorian
// date (1970..2106) and time of day. Fully pipelined: a new item may be started
// every cycle, busy never rises, and each result appears with out_valid for one
// cycle. Most of the pipeline is the eight-stage binary search over year start
// days, after three stages that split days from time of day and three that
// resolve month and day. The receiver cannot stall; results must be taken in
// the cycle they appear.

module epoch_seconds_to_calendar_unit
  import e2c_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_epoch_seconds,
  output logic             out_valid,
  output logic [4:0]       out_day_of_month,
  output logic [3:0]       out_month_number,
  output logic [11:0]      out_year_number,
  output logic [4:0]       out_hour_of_day,
  output logic [5:0]       out_minute_of_hour,
  output logic [5:0]       out_second_of_minute
);

  // clock path is 4 stages, date path after the split is 11
  localparam int ClkPad = 7;

  logic   split_valid;
  days_t  split_days;
  tod_t   split_tod;
  logic   year_valid;
  days_t  year_days;
  yoff_t  year_yoff;
  clock_t clk_time;
  clock_t clk_dly_r [ClkPad];

  assign busy = 1'b0;

  e2c_day_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_secs   (in_epoch_seconds),
    .out_valid (split_valid),
    .out_days  (split_days),
    .out_tod   (split_tod)
  );

  e2c_year_search u_year (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (split_valid),
    .in_days   (split_days),
    .out_valid (year_valid),
    .out_days  (year_days),
    .out_yoff  (year_yoff)
  );

  e2c_month_day u_mday (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (year_valid),
    .in_days   (year_days),
    .in_yoff   (year_yoff),
    .out_valid (out_valid),
    .out_day   (out_day_of_month),
    .out_month (out_month_number),
    .out_year  (out_year_number)
  );

  e2c_clock u_clock (
    .clk      (clk),
    .in_tod   (split_tod),
    .out_time (clk_time)
  );

  always_ff @(posedge clk) begin
    clk_dly_r[0] <= clk_time;
    for (int i = 1; i < ClkPad; i++) begin
      clk_dly_r[i] <= clk_dly_r[i-1];
    end
  end

  assign out_hour_of_day      = clk_dly_r[ClkPad-1].hour;
  assign out_minute_of_hour   = clk_dly_r[ClkPad-1].minute;
  assign out_second_of_minute = clk_dly_r[ClkPad-1].second;

endmodule

`default_nettype wire

// ===== rtl/e2c_day_split.sv =====
`timescale 1ns / 1ps
`default_nettype none

module e2c_day_split
  import e2c_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  input  wire epoch_t in_secs,
  output logic        out_valid,
  output days_t       out_days,
  output tod_t        out_tod
);

  logic        v1_r, v2_r, v3_r;
  logic [50:0] p1_r;
  epoch_t      secs1_r, secs2_r;
  days_t       days2_r, days3_r;
  epoch_t      dm2_r;
  tod_t        tod3_r;
  days_t       days1;
  logic [32:0] dm_full;

  // secs / 86400 = (secs >> 7) / 675
  assign days1   = p1_r[DayRecipShift +: DaysWidth];
  assign dm_full = 33'(days1) * 33'(SecsPerDay);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r    <= 51'(in_secs[EpochWidth-1:7]) * 51'(DayRecip);
    secs1_r <= in_secs;
    days2_r <= days1;
    dm2_r   <= dm_full[EpochWidth-1:0];
    secs2_r <= secs1_r;
    days3_r <= days2_r;
    tod3_r  <= tod_t'(secs2_r - dm2_r);
  end

  assign out_valid = v3_r;
  assign out_days  = days3_r;
  assign out_tod   = tod3_r;

endmodule

`default_nettype wire

// ===== rtl/e2c_year_search.sv =====
`timescale 1ns / 1ps
`default_nettype none

module e2c_year_search
  import e2c_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire days_t in_days,
  output logic       out_valid,
  output days_t      out_days,
  output yoff_t      out_yoff
);

  localparam int Steps = YoffWidth;

  logic  v_r    [Steps];
  days_t days_r [Steps];
  yoff_t yoff_r [Steps];

  // one bit of the year offset per stage, msb first
  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic  vin;
    days_t din;
    yoff_t yin;
    yoff_t cand;
    logic  take;

    if (s == 0) begin : g_first
      assign vin = in_valid;
      assign din = in_days;
      assign yin = '0;
    end else begin : g_next
      assign vin = v_r[s-1];
      assign din = days_r[s-1];
      assign yin = yoff_r[s-1];
    end

    assign cand = yin | (yoff_t'(1) << (Steps - 1 - s));
    assign take = (cand <= yoff_t'(LastYoff)) && (year_start(cand) <= 17'(din));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      days_r[s] <= din;
      yoff_r[s] <= take ? cand : yin;
    end
  end

  assign out_valid = v_r[Steps-1];
  assign out_days  = days_r[Steps-1];
  assign out_yoff  = yoff_r[Steps-1];

endmodule

`default_nettype wire

// ===== rtl/e2c_month_day.sv =====
`timescale 1ns / 1ps
`default_nettype none

module e2c_month_day
  import e2c_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire days_t in_days,
  input  wire yoff_t in_yoff,
  output logic       out_valid,
  output logic [4:0] out_day,
  output logic [3:0] out_month,
  output logic [11:0] out_year
);

  logic        v1_r, v2_r, v3_r;
  doy_t        doy1_r, doy2_r;
  logic        leap1_r, leap2_r;
  logic [11:0] year1_r, year2_r, year3_r;
  midx_t       midx2_r;
  logic [4:0]  day3_r;
  logic [3:0]  month3_r;
  logic [16:0] doy_full;
  midx_t       midx;
  doy_t        day0;

  assign doy_full = 17'(in_days) - year_start(in_yoff);

  // month index = number of later month starts already reached
  always_comb begin
    midx = '0;
    for (int m = 1; m < Months; m++) begin
      if (doy1_r >= month_start(midx_t'(m), leap1_r)) begin
        midx = midx + midx_t'(1);
      end
    end
  end

  assign day0 = doy2_r - month_start(midx2_r, leap2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    doy1_r   <= doy_full[DoyWidth-1:0];
    leap1_r  <= is_leap(in_yoff);
    year1_r  <= 12'(FirstYear) + 12'(in_yoff);
    doy2_r   <= doy1_r;
    leap2_r  <= leap1_r;
    year2_r  <= year1_r;
    midx2_r  <= midx;
    day3_r   <= day0[4:0] + 5'd1;
    month3_r <= midx2_r + 4'd1;
    year3_r  <= year2_r;
  end

  assign out_valid = v3_r;
  assign out_day   = day3_r;
  assign out_month = month3_r;
  assign out_year  = year3_r;

endmodule

`default_nettype wire

// ===== rtl/e2c_clock.sv =====
`timescale 1ns / 1ps
`default_nettype none

module e2c_clock
  import e2c_pkg::*;
(
  input  wire logic clk,
  input  wire tod_t in_tod,
  output clock_t    out_time
);

  logic [25:0] ph1_r;
  tod_t        tod1_r;
  logic [4:0]  hour2_r, hour3_r;
  logic [11:0] rem2_r, rem3_r;
  logic [20:0] pm3_r;
  clock_t      time4_r;
  logic [4:0]  hour;
  logic [16:0] rem_full;
  logic [5:0]  minute;
  logic [11:0] msec;

  // tod / 3600 = (tod >> 4) / 225
  assign hour     = ph1_r[HourRecipShift +: 5];
  assign rem_full = tod1_r - 17'(hour) * 17'(SecsPerHour);
  // rem / 60 = (rem >> 2) / 15
  assign minute   = pm3_r[MinRecipShift +: 6];
  assign msec     = 12'(minute) * 12'(SecsPerMin);

  always_ff @(posedge clk) begin
    ph1_r          <= 26'(in_tod[TodWidth-1:4]) * 26'(HourRecip);
    tod1_r         <= in_tod;
    hour2_r        <= hour;
    rem2_r         <= rem_full[11:0];
    pm3_r          <= 21'(rem2_r[11:2]) * 21'(MinRecip);
    rem3_r         <= rem2_r;
    hour3_r        <= hour2_r;
    time4_r.hour   <= hour3_r;
    time4_r.minute <= minute;
    time4_r.second <= 6'(rem3_r - msec);
  end

  assign out_time = time4_r;

endmodule

`default_nettype wire

// ===== tb/epoch_seconds_to_calendar_unit_test.sv =====
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_unit_test;
  import e2c_pkg::*;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } stamp_t;

  typedef struct packed {
    logic [31:0] epoch;
    logic        typed;
    stamp_t      want;
  } row_t;

  localparam int NumDirected = 18;
  localparam int NumRandom = 1750 - NumDirected;
  localparam int Latency = 14;
  localparam int CycleLimit = 1_000_000;
  localparam int DaysInMonth [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam logic [31:0] LastDay = 32'd49709;  // last day with a full 86400 seconds

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_epoch_seconds;
  logic        out_valid;
  logic [4:0]  out_day_of_month;
  logic [3:0]  out_month_number;
  logic [11:0] out_year_number;
  logic [4:0]  out_hour_of_day;
  logic [5:0]  out_minute_of_hour;
  logic [5:0]  out_second_of_minute;

  stamp_t pending_dates [$];
  stamp_t next_stamp;
  row_t   directed_rows [NumDirected];
  int     error_count = 0;
  int     cycle_count = 0;

  epoch_seconds_to_calendar_unit DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_epoch_seconds    (in_epoch_seconds),
    .out_valid           (out_valid),
    .out_day_of_month    (out_day_of_month),
    .out_month_number    (out_month_number),
    .out_year_number     (out_year_number),
    .out_hour_of_day     (out_hour_of_day),
    .out_minute_of_hour  (out_minute_of_hour),
    .out_second_of_minute(out_second_of_minute)
  );

  always #1 clk = ~clk;

  function automatic logic leap_year(input logic [31:0] yr);
    return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
  endfunction

  function automatic stamp_t to_calendar(input logic [31:0] secs);
    logic [31:0] days;
    logic [31:0] tod;
    logic [31:0] yr;
    logic [31:0] ylen;
    logic [31:0] mlen;
    logic [31:0] m;
    logic        leap;
    stamp_t      r;
    days = secs / SecsPerDay;
    tod  = secs % SecsPerDay;
    yr   = FirstYear;
    m    = 0;
    while (1) begin
      ylen = leap_year(yr) ? 32'd366 : 32'd365;
      if (days < ylen) break;
      days = days - ylen;
      yr = yr + 1;
    end
    leap = leap_year(yr);
    while (m < 11) begin
      mlen = (m == 1 && leap) ? 32'd29 : DaysInMonth[m];
      if (days < mlen) break;
      days = days - mlen;
      m = m + 1;
    end
    r.day    = 5'(days + 1);
    r.month  = 4'(m + 1);
    r.year   = 12'(yr);
    r.hour   = 5'(tod / SecsPerHour);
    r.minute = 6'((tod % SecsPerHour) / SecsPerMin);
    r.second = 6'(tod % SecsPerMin);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // results are taken at the edge that ends their strobe cycle
  always @(posedge clk) begin
    stamp_t want;
    if (rst_n) begin
      if (start && busy === 1'b0) pending_dates.push_back(next_stamp);
      if (out_valid === 1'b1) begin
        if (pending_dates.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d-%0d-%0d", $time,
                   out_year_number, out_month_number, out_day_of_month);
          error_count++;
        end else begin
          want = pending_dates.pop_front();
          check_field("day_of_month", 32'(want.day), 32'(out_day_of_month));
          check_field("month_number", 32'(want.month), 32'(out_month_number));
          check_field("year_number", 32'(want.year), 32'(out_year_number));
          check_field("hour_of_day", 32'(want.hour), 32'(out_hour_of_day));
          check_field("minute_of_hour", 32'(want.minute), 32'(out_minute_of_hour));
          check_field("second_of_minute", 32'(want.second), 32'(out_second_of_minute));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("epoch_seconds_to_calendar_unit regression: fail");
      $finish;
    end
  end

  // called just after a falling edge, returns just after the falling edge past acceptance
  task automatic send_item(input logic [31:0] secs, input stamp_t want, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    next_stamp = want;
    start <= 1'b1;
    in_epoch_seconds <= secs;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  task automatic drain_pending();
    start <= 1'b0;
    do @(negedge clk); while (pending_dates.size() != 0);
    repeat (Latency + 4) @(negedge clk);
  endtask

  initial begin
    logic [31:0] secs;
    logic [31:0] day_idx;
    logic        calm;
    int          kind;
    int          gap;
    rst_n = 1'b0;
    start = 1'b0;
    in_epoch_seconds = '0;
    next_stamp = '0;

    directed_rows = '{
      '{32'd0,          1'b1, '{5'd1,  4'd1, 12'd1970, 5'd0,  6'd0,  6'd0}},
      '{32'hFFFF_FFFF,  1'b1, '{5'd7,  4'd2, 12'd2106, 5'd6,  6'd28, 6'd15}},
      '{32'd86399,      1'b1, '{5'd1,  4'd1, 12'd1970, 5'd23, 6'd59, 6'd59}},
      '{32'd86400,      1'b1, '{5'd2,  4'd1, 12'd1970, 5'd0,  6'd0,  6'd0}},
      '{32'd31535999,   1'b1, '{5'd31, 4'd12, 12'd1970, 5'd23, 6'd59, 6'd59}},
      '{32'd31536000,   1'b1, '{5'd1,  4'd1, 12'd1971, 5'd0,  6'd0,  6'd0}},
      '{32'd1,          1'b0, '0},
      '{32'd68169600,   1'b0, '0},   // 1972 leap day
      '{32'd94694399,   1'b0, '0},   // last second of 1972
      '{32'd951782400,  1'b0, '0},   // 2000 is a leap year by the 400 rule
      '{32'd978220799,  1'b0, '0},
      '{32'd4102444800, 1'b0, '0},   // 2100 begins
      '{32'd4107542399, 1'b0, '0},   // 2100 has no leap day
      '{32'd4107542400, 1'b0, '0},
      '{32'd2147483647, 1'b0, '0},
      '{32'd2147483648, 1'b0, '0},
      '{32'hAAAA_AAAA,  1'b0, '0},
      '{32'h5555_5555,  1'b0, '0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].epoch,
                directed_rows[i].typed ? directed_rows[i].want
                                       : to_calendar(directed_rows[i].epoch),
                $urandom_range(0, 5));
    end
    drain_pending();

    calm = 1'b0;
    for (int n = 0; n < NumRandom; n++) begin
      if (n % 128 == 0) calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        secs = $urandom();
      end else if (kind <= 6) begin
        // land on the edges of a day, which reach month and year rollovers
        day_idx = $urandom_range(0, LastDay);
        secs = day_idx * SecsPerDay;
        case ($urandom_range(0, 3))
          0: secs = secs;
          1: secs = secs + 1;
          2: secs = secs + SecsPerDay - 2;
          default: secs = secs + SecsPerDay - 1;
        endcase
      end else if (kind <= 8) begin
        secs = 32'hFFFF_FFFF - $urandom_range(0, 40_000_000);
      end else begin
        secs = $urandom_range(0, 40_000_000);
      end
      gap = calm ? 0 : $urandom_range(0, 5);
      send_item(secs, to_calendar(secs), gap);
      if ($urandom_range(0, 249) == 0) drain_pending();
    end

    drain_pending();
    repeat (2 * Latency) @(negedge clk);
    if (error_count == 0) begin
      $display("epoch_seconds_to_calendar_unit regression: pass");
    end else begin
      $display("epoch_seconds_to_calendar_unit regression: fail");
    end
    $finish;
  end

endmodule
